/* rtl/sfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	// Default sizes
	localparam int SFR_MAX_PATTERN     = 8;
	localparam int SFR_MAX_REPLACEMENT = 8;
	localparam int SFR_LIMIT_WIDTH     = 32;

	// Configuration port
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int LEN_W       = 4;
	localparam int CFG_LIMIT_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LIMIT     = 3'd5;

	// One result item as held in the output queue
	typedef struct packed {
		logic [7:0] ob;
		logic       has;
		logic       eos;
	} res_entry_t;

endpackage

`default_nettype wire

/* rtl/sfr_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one byte or an end-of-string mark per item
interface sfr_feed_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] in_byte;

	modport source (output valid, output func, output in_byte, input ready);
	modport sink (input valid, input func, input in_byte, output ready);
endinterface

// Result channel
interface sfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_string;

	modport source (output valid, output out_byte, output has_byte, output end_of_string,
		input ready);
	modport sink (input valid, input out_byte, input has_byte, input end_of_string,
		output ready);
endinterface

`default_nettype wire

/* rtl/string_find_replace_stream.sv */
// Streaming find and replace with a replacement count limit.
// Channel feed takes one item per byte (func = 0) and one end item (func = 1)
// that closes the string. Channel result gives the output string one byte per
// item; end_of_string marks its last item, and an item with has_byte = 0 stands
// for an empty result string. The configuration port (wr_en, wr_index, wr_data)
// is written between strings; a string uses the values present at its first item.
// Results of an accepted item are loaded into the registered result queue cells.
// Throughput: one item per cycle while each item gives at most one result and
// the receiver takes every result. An item giving n results (a replacement
// burst or a window flush, up to nine) loads them into the queue together;
// feed is ready while at most one result is pending.
// Matching is resolved in the same cycle the byte is accepted, across the row of
// window cells, so a byte never waits for a later cycle to decide.
// Reset clears the configuration, empties the window and the result queue.
// When the receiver stalls, the head result holds and feed drops ready as soon
// as two results are pending.
`timescale 1ns / 1ps
`default_nettype none

module string_find_replace_stream
	import sfr_pkg::*;
#(
	parameter int MAX_PATTERN     = SFR_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = SFR_MAX_REPLACEMENT,
	parameter int LIMIT_WIDTH     = SFR_LIMIT_WIDTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	sfr_feed_if.sink             feed,
	sfr_result_if.source         result,
	input  wire                  wr_en,
	input  wire  [CFG_IDX_W-1:0] wr_index,
	input  wire  [CFG_DATA_W-1:0] wr_data
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int LOAD_N = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT + 1;
	localparam int QN     = LOAD_N + 1;
	localparam int CNT_W  = $clog2(QN + 1);

	// Configuration registers
	logic [63:0]            pattern_bytes_q;
	logic [LEN_W-1:0]       pattern_length_q;
	logic [63:0]            replacement_bytes_q;
	logic [LEN_W-1:0]       replacement_length_q;
	logic                   limit_enabled_q;
	logic [CFG_LIMIT_W-1:0] replace_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= '0;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
			limit_enabled_q      <= 1'b0;
			replace_limit_q      <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PATTERN_BYTES:     pattern_bytes_q      <= wr_data[63:0];
				REG_PATTERN_LENGTH:    pattern_length_q     <= wr_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES: replacement_bytes_q  <= wr_data[63:0];
				REG_REPLACEMENT_LEN:   replacement_length_q <= wr_data[LEN_W-1:0];
				REG_LIMIT_ENABLED:     limit_enabled_q      <= wr_data[0];
				REG_REPLACE_LIMIT:     replace_limit_q      <= wr_data[CFG_LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Live values as a new string would see them
	logic [LEN_W-1:0]       live_plen, live_rlen;
	logic [LIMIT_WIDTH-1:0] live_limit;

	assign live_plen = (pattern_length_q > LEN_W'(MAX_PATTERN)) ?
		LEN_W'(MAX_PATTERN) : pattern_length_q;
	assign live_rlen = (replacement_length_q > LEN_W'(MAX_REPLACEMENT)) ?
		LEN_W'(MAX_REPLACEMENT) : replacement_length_q;

	generate
		if (LIMIT_WIDTH >= CFG_LIMIT_W) begin : g_lim_wide
			assign live_limit = LIMIT_WIDTH'(replace_limit_q);
		end else begin : g_lim_sat
			assign live_limit = (|replace_limit_q[CFG_LIMIT_W-1:LIMIT_WIDTH]) ?
				{LIMIT_WIDTH{1'b1}} : replace_limit_q[LIMIT_WIDTH-1:0];
		end
	endgenerate

	// Per-string state
	logic                   started_q;
	logic [FILL_W-1:0]      fill_q;
	logic [LIMIT_WIDTH-1:0] left_q;
	logic [63:0]            cur_pat_q, cur_rep_q;
	logic [LEN_W-1:0]       cur_plen_q, cur_rlen_q;
	logic                   cur_lim_q;

	logic [63:0]            eff_pat, eff_rep;
	logic [LEN_W-1:0]       eff_plen, eff_rlen;
	logic                   eff_lim;
	logic [LIMIT_WIDTH-1:0] eff_left;

	assign eff_pat  = started_q ? cur_pat_q  : pattern_bytes_q;
	assign eff_rep  = started_q ? cur_rep_q  : replacement_bytes_q;
	assign eff_plen = started_q ? cur_plen_q : live_plen;
	assign eff_rlen = started_q ? cur_rlen_q : live_rlen;
	assign eff_lim  = started_q ? cur_lim_q  : limit_enabled_q;
	assign eff_left = started_q ? left_q     : live_limit;

	logic can_rep, ins_mode, is_end;
	assign can_rep  = !eff_lim || (eff_left != '0);
	assign ins_mode = (eff_plen == '0);
	assign is_end   = feed.func;

	// Window cells
	logic [MAX_PATTERN-1:0][7:0]             pat_b;
	logic [MAX_PATTERN-1:0][7:0]             win_b;
	logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] win_eq;
	logic [MAX_PATTERN-1:0][7:0]             win_d;
	logic                                    win_ld;

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pat_b[j] = eff_pat[8*j +: 8];
		end
	end

	generate
		for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_win
			sfr_win_cell #(
				.MAX_PATTERN(MAX_PATTERN)
			) u_cell (
				.clk (clk),
				.ld  (win_ld),
				.d   (win_d[c]),
				.pat (pat_b),
				.q   (win_b[c]),
				.eq  (win_eq[c])
			);
		end
	endgenerate

	// Window with the new byte appended
	logic [FILL_W-1:0]          f1;
	logic [LOAD_N-1:0][7:0]     wn;
	logic [MAX_PATTERN-1:0]     nb_eq;

	assign f1 = fill_q + FILL_W'(1);

	generate
		for (genvar i = 0; i < LOAD_N; i++) begin : g_wn
			if (i < MAX_PATTERN) begin : g_in
				assign wn[i] = (FILL_W'(i) < fill_q) ? win_b[i] : feed.in_byte;
			end else begin : g_out
				assign wn[i] = feed.in_byte;
			end
		end
	endgenerate

	// Prefix test at every shift of the extended window
	logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] weq;
	logic [MAX_PATTERN-1:0]                  pre;
	logic [FILL_W-1:0]                       kmin, ksel;
	logic                                    rep_match;

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			nb_eq[j] = (feed.in_byte == pat_b[j]);
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				weq[i][j] = (FILL_W'(i) < fill_q) ? win_eq[i][j] : nb_eq[j];
			end
		end
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pre[k] = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if ((k + j < MAX_PATTERN) && (FILL_W'(k + j) < f1)) begin
					pre[k] = pre[k] & weq[k+j][j];
				end
			end
		end
		kmin = f1;
		for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
			if ((FILL_W'(k) < f1) && pre[k]) begin
				kmin = FILL_W'(k);
			end
		end
	end

	assign ksel      = can_rep ? kmin : f1;
	assign rep_match = !ins_mode && (LEN_W'(f1) == eff_plen) && can_rep && pre[0];

	// Shifted window after releasing ksel bytes
	generate
		for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_wd
			always_comb begin
				win_d[c] = feed.in_byte;
				for (int s = 0; s < MAX_PATTERN - c; s++) begin
					if (ksel == FILL_W'(s)) begin
						win_d[c] = wn[c+s];
					end
				end
			end
		end
	endgenerate

	// Result items of the current input item
	logic                          use_rep;
	logic [LEN_W-1:0]              rl;
	logic [CNT_W-1:0]              n_raw, n_res;
	res_entry_t [QN-1:0]           load_e;
	logic [7:0]                    eb;

	always_comb begin
		use_rep = 1'b0;
		rl      = '0;
		n_raw   = '0;
		if (is_end) begin
			if (ins_mode) begin
				use_rep = 1'b1;
				rl      = can_rep ? eff_rlen : '0;
				n_raw   = CNT_W'(rl);
			end else begin
				n_raw = CNT_W'(fill_q);
			end
		end else if (ins_mode) begin
			use_rep = 1'b1;
			rl      = can_rep ? eff_rlen : '0;
			n_raw   = CNT_W'(rl) + CNT_W'(1);
		end else if (rep_match) begin
			use_rep = 1'b1;
			rl      = eff_rlen;
			n_raw   = CNT_W'(eff_rlen);
		end else begin
			n_raw = CNT_W'(ksel);
		end

		load_e = '0;
		for (int i = 0; i < LOAD_N; i++) begin
			if (use_rep) begin
				eb = (LEN_W'(i) < rl) ? eff_rep[8*(i%8) +: 8] : feed.in_byte;
			end else begin
				eb = wn[i];
			end
			load_e[i].ob  = eb;
			load_e[i].has = 1'b1;
			load_e[i].eos = is_end && (CNT_W'(i) == n_raw - CNT_W'(1));
		end

		n_res = n_raw;
		// Empty result string: one marker item
		if (is_end && (n_raw == '0)) begin
			load_e[0].ob  = 8'h00;
			load_e[0].has = 1'b0;
			load_e[0].eos = 1'b1;
			n_res         = CNT_W'(1);
		end
	end

	// Result queue
	logic [CNT_W-1:0]   cnt_q, base;
	logic               pop, acc, rep_used;
	res_entry_t [QN-1:0] q_e;
	logic [QN-1:0]      q_ld;

	assign result.valid = (cnt_q != '0);
	assign pop          = result.valid && result.ready;
	assign feed.ready   = (cnt_q <= CNT_W'(1));
	assign acc          = feed.valid && feed.ready;
	assign base         = ((cnt_q == CNT_W'(1)) && !pop) ? CNT_W'(1) : '0;
	assign win_ld       = acc && !is_end;
	assign rep_used     = acc && ((ins_mode && can_rep) || (!is_end && rep_match));

	generate
		for (genvar c = 0; c < QN; c++) begin : g_q
			res_entry_t d_load, d_next;

			assign q_ld[c] = acc && (CNT_W'(c) >= base) && (CNT_W'(c) < base + n_res);

			if (c == 0) begin : g_head
				assign d_load = load_e[0];
			end else begin : g_body
				assign d_load = (base != '0) ? load_e[c-1] : load_e[c];
			end

			if (c == QN - 1) begin : g_tail
				assign d_next = '0;
			end else begin : g_mid
				assign d_next = q_e[c+1];
			end

			sfr_out_cell u_cell (
				.clk    (clk),
				.ld     (q_ld[c]),
				.shift  (pop),
				.d_load (d_load),
				.d_next (d_next),
				.q      (q_e[c])
			);
		end
	endgenerate

	assign result.out_byte      = q_e[0].ob;
	assign result.has_byte      = q_e[0].has;
	assign result.end_of_string = q_e[0].eos;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			started_q <= 1'b0;
			fill_q    <= '0;
			left_q    <= '0;
		end else begin
			cnt_q <= cnt_q - (pop ? CNT_W'(1) : '0) + (acc ? n_res : '0);
			if (acc) begin
				left_q <= eff_left - ((rep_used && eff_lim) ? LIMIT_WIDTH'(1) : '0);
				if (is_end) begin
					started_q <= 1'b0;
					fill_q    <= '0;
				end else begin
					started_q <= 1'b1;
					if (ins_mode || rep_match) begin
						fill_q <= '0;
					end else begin
						fill_q <= f1 - ksel;
					end
				end
			end
		end
	end

	// Configuration captured at string start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pat_q  <= '0;
			cur_rep_q  <= '0;
			cur_plen_q <= '0;
			cur_rlen_q <= '0;
			cur_lim_q  <= 1'b0;
		end else if (acc && !started_q) begin
			cur_pat_q  <= pattern_bytes_q;
			cur_rep_q  <= replacement_bytes_q;
			cur_plen_q <= live_plen;
			cur_rlen_q <= live_rlen;
			cur_lim_q  <= limit_enabled_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/sfr_win_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One byte of the match window, compared against every pattern byte
module sfr_win_cell
	import sfr_pkg::*;
#(
	parameter int MAX_PATTERN = SFR_MAX_PATTERN
) (
	input  wire                             clk,
	input  wire                             ld,
	input  wire  [7:0]                      d,
	input  wire  [MAX_PATTERN-1:0][7:0]     pat,
	output logic [7:0]                      q,
	output logic [MAX_PATTERN-1:0]          eq
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			byte_q <= d;
		end
	end

	// Match flags for every alignment against the pattern
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			eq[j] = (byte_q == pat[j]);
		end
	end

	assign q = byte_q;

endmodule

`default_nettype wire

/* rtl/sfr_out_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One slot of the result queue; shifts toward the head on a pop unless it is loaded
module sfr_out_cell
	import sfr_pkg::*;
(
	input  wire              clk,
	input  wire              ld,
	input  wire              shift,
	input  wire res_entry_t  d_load,
	input  wire res_entry_t  d_next,
	output res_entry_t       q
);

	res_entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			entry_q <= d_load;
		end else if (shift) begin
			entry_q <= d_next;
		end
	end

	assign q = entry_q;

endmodule

`default_nettype wire

/* rtl/sfr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfr_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       feed_valid,
	input wire       feed_ready,
	input wire       feed_func,
	input wire       result_valid,
	input wire       result_ready,
	input wire [7:0] result_out_byte,
	input wire       result_has_byte,
	input wire       result_eos
);

	// A stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			$stable(result_out_byte) && $stable(result_has_byte) && $stable(result_eos))
		else $error("result payload changed while stalled");

	// An empty-string marker is a zero byte that closes the string
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_has_byte |-> result_eos && (result_out_byte == 8'h00))
		else $error("malformed empty-string marker");

	// An end item always yields at least one result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && feed_ready && feed_func |=> result_valid)
		else $error("end item gave no result");

	// Back-pressure only while results are pending
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!feed_ready |-> result_valid)
		else $error("feed stalled with empty result queue");

endmodule

bind string_find_replace_stream sfr_checker u_sfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.feed_valid      (feed.valid),
	.feed_ready      (feed.ready),
	.feed_func       (feed.func),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_out_byte (result.out_byte),
	.result_has_byte (result.has_byte),
	.result_eos      (result.end_of_string)
);

`default_nettype wire

/* tb/string_find_replace_stream_tb.sv */
`timescale 1ns / 1ps

module string_find_replace_stream_tb;
	import sfr_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam int LONG_HOLD     = 80;
	localparam int RANDOM_ITEMS  = 90;
	localparam int MAX_PRINTS    = 40;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed stimulus
	typedef struct {
		row_kind_t             kind;
		logic                  fn;
		logic [7:0]            b;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		bit                    typed;
		res_entry_t            want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	sfr_feed_if   feed_ch();
	sfr_result_if result_ch();

	string_find_replace_stream uut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_ch),
		.result(result_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Register shadows, as written
	logic [CFG_DATA_W-1:0]  cfg_pattern;
	logic [LEN_W-1:0]       cfg_pat_len;
	logic [CFG_DATA_W-1:0]  cfg_repl;
	logic [LEN_W-1:0]       cfg_repl_len;
	logic                   cfg_limit_on;
	logic [CFG_LIMIT_W-1:0] cfg_limit;

	// Per-string copy of the settings and the match window
	logic [CFG_DATA_W-1:0]      str_pattern;
	logic [CFG_DATA_W-1:0]      str_repl;
	int                         str_pat_len;
	int                         str_repl_len;
	bit                         str_limited;
	logic [SFR_LIMIT_WIDTH-1:0] repl_left;
	bit                         in_string;
	logic [7:0]                 held_bytes [SFR_MAX_PATTERN];
	int                         held_count;

	res_entry_t step_results[$];
	res_entry_t pending_results[$];

	int  error_count;
	int  results_checked;
	int  items_sent;
	int  strings_done;
	int  reg_writes;
	bit  hold_request;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial clk = 1'b0;

	// ---------------- find/replace predictor ----------------

	function automatic void emit_result(input logic [7:0] b, input logic has);
		res_entry_t e;
		e.ob  = b;
		e.has = has;
		e.eos = 1'b0;
		step_results.push_back(e);
	endfunction

	function automatic bit can_replace();
		return !str_limited || repl_left != 0;
	endfunction

	function automatic void emit_replacement();
		for (int i = 0; i < str_repl_len; i++)
			emit_result(str_repl[8*i +: 8], 1'b1);
		if (str_limited)
			repl_left--;
	endfunction

	function automatic bit held_is_prefix();
		for (int i = 0; i < held_count; i++)
			if (held_bytes[i] != str_pattern[8*i +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void release_oldest();
		emit_result(held_bytes[0], 1'b1);
		for (int i = 0; i < SFR_MAX_PATTERN - 1; i++)
			held_bytes[i] = held_bytes[i+1];
		held_bytes[SFR_MAX_PATTERN-1] = 8'h00;
		held_count--;
	endfunction

	// Result items caused by one input item, left in step_results
	function automatic void predict_find_replace(input logic fn, input logic [7:0] b);
		res_entry_t tail;
		bit         scanning;
		step_results.delete();
		// settings are latched by the first item of a string
		if (!in_string) begin
			str_pattern  = cfg_pattern;
			str_repl     = cfg_repl;
			str_pat_len  = (cfg_pat_len > SFR_MAX_PATTERN) ? SFR_MAX_PATTERN : int'(cfg_pat_len);
			str_repl_len = (cfg_repl_len > SFR_MAX_REPLACEMENT) ?
				SFR_MAX_REPLACEMENT : int'(cfg_repl_len);
			str_limited  = cfg_limit_on;
			repl_left    = cfg_limit;
			held_count   = 0;
			in_string    = 1'b1;
		end
		if (!fn && str_pat_len == 0) begin
			// insertion mode: replacement goes in front of every byte while the limit allows
			if (can_replace())
				emit_replacement();
			emit_result(b, 1'b1);
		end else if (!fn) begin
			if (held_count < SFR_MAX_PATTERN) begin
				held_bytes[held_count] = b;
				held_count++;
			end
			scanning = 1'b1;
			while (scanning) begin
				if (held_count == str_pat_len && can_replace() && held_is_prefix()) begin
					emit_replacement();
					held_count = 0;
				end else if (held_count > 0 && (held_count >= str_pat_len || !can_replace() ||
					!held_is_prefix())) begin
					release_oldest();
				end else begin
					scanning = 1'b0;
				end
			end
		end else begin
			// end of string: trailing insertion or window flush
			if (str_pat_len == 0) begin
				if (can_replace())
					emit_replacement();
			end else begin
				while (held_count > 0)
					release_oldest();
			end
			if (step_results.size() == 0)
				emit_result(8'h00, 1'b0);
			tail = step_results.pop_back();
			tail.eos = 1'b1;
			step_results.push_back(tail);
			held_count = 0;
			for (int i = 0; i < SFR_MAX_PATTERN; i++)
				held_bytes[i] = 8'h00;
			in_string = 1'b0;
		end
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want_v);
		if (error_count < MAX_PRINTS)
			$display("%0t ns: %s, got %h expected %h", $time, what, got, want_v);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		res_entry_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result item with nothing expected", result_ch.out_byte, 8'h00);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.out_byte !== want.ob)
					report_mismatch("out_byte", result_ch.out_byte, want.ob);
				if (result_ch.has_byte !== want.has)
					report_mismatch("has_byte", 8'(result_ch.has_byte), 8'(want.has));
				if (result_ch.end_of_string !== want.eos)
					report_mismatch("end_of_string", 8'(result_ch.end_of_string), 8'(want.eos));
				results_checked++;
			end
		end
	end

	// ---------------- result side: random stalls plus one long hold ----------------

	initial begin : result_side
		int  stall_left;
		int  calm_left;
		int  r;
		bit  rdy;
		result_ch.ready = 1'b0;
		stall_left = 0;
		calm_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (stall_left > 0) begin
					stall_left--;
					rdy = 1'b0;
				end else if (calm_left > 0) begin
					calm_left--;
					rdy = 1'b1;
				end else begin
					r = $urandom_range(0, 19);
					rdy = 1'b1;
					if (r < 3) begin
						stall_left = $urandom_range(0, 2);
						rdy = 1'b0;
					end else if (r == 3) begin
						stall_left = $urandom_range(8, 30);
						rdy = 1'b0;
					end else if (r == 4) begin
						calm_left = $urandom_range(20, 60);
					end
				end
				result_ch.ready <= rdy;
			end
		end
	end

	// ---------------- feed side ----------------

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm || hold_request)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	task automatic idle_feed(input int n);
		if (n > 0) begin
			@(negedge clk);
			feed_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Offer one item, wait for the handshake, then queue what it should produce
	task automatic send_item(input logic fn, input logic [7:0] b, input bit typed,
		input res_entry_t want);
		@(negedge clk);
		feed_ch.valid   <= 1'b1;
		feed_ch.func    <= fn;
		feed_ch.in_byte <= b;
		do @(posedge clk); while (!feed_ch.ready);
		predict_find_replace(fn, b);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (step_results[i])
				pending_results.push_back(step_results[i]);
		items_sent++;
		if (fn)
			strings_done++;
	endtask

	task automatic send_byte(input logic fn, input logic [7:0] b, input bit calm);
		idle_feed(pick_gap(calm));
		send_item(fn, b, 1'b0, '0);
	endtask

	// Drop valid, let every expected item arrive, then wait out the settle period
	task automatic settle();
		@(negedge clk);
		feed_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_PATTERN_BYTES:     cfg_pattern = data;
			REG_PATTERN_LENGTH:    cfg_pat_len = data[LEN_W-1:0];
			REG_REPLACEMENT_BYTES: cfg_repl = data;
			REG_REPLACEMENT_LEN:   cfg_repl_len = data[LEN_W-1:0];
			REG_LIMIT_ENABLED:     cfg_limit_on = data[0];
			REG_REPLACE_LIMIT:     cfg_limit = data[CFG_LIMIT_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Random settings; the pattern is drawn mostly from a three-letter alphabet so matches are common
	task automatic random_settings();
		logic [CFG_DATA_W-1:0] pat;
		int r;
		for (int i = 0; i < SFR_MAX_PATTERN; i++) begin
			if ($urandom_range(0, 4) != 0)
				pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
			else
				pat[8*i +: 8] = 8'($urandom);
		end
		write_reg(REG_PATTERN_BYTES, pat);
		r = $urandom_range(0, 9);
		if (r == 0)
			write_reg(REG_PATTERN_LENGTH, 64'd0);
		else if (r < 7)
			write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(1, 3)));
		else if (r < 9)
			write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(4, 8)));
		else
			write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(9, 15)));
		write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_REPLACEMENT_LEN, CFG_DATA_W'($urandom_range(9, 15)));
		else
			write_reg(REG_REPLACEMENT_LEN, CFG_DATA_W'($urandom_range(0, 8)));
		write_reg(REG_LIMIT_ENABLED, CFG_DATA_W'($urandom_range(0, 1)));
		r = $urandom_range(0, 9);
		if (r < 7)
			write_reg(REG_REPLACE_LIMIT, CFG_DATA_W'($urandom_range(0, 3)));
		else if (r < 9)
			write_reg(REG_REPLACE_LIMIT, CFG_DATA_W'($urandom_range(4, 20)));
		else
			write_reg(REG_REPLACE_LIMIT, {$urandom, $urandom});
	endtask

	// A string built from whole patterns, pattern prefixes and loose bytes
	task automatic random_string(input bit well_formed, input bit calm, input int max_pieces);
		int         pieces;
		int         plen;
		int         pick;
		int         cut;
		int         pos;
		logic [7:0] sym;
		pieces = $urandom_range(0, max_pieces);
		plen = (cfg_pat_len > SFR_MAX_PATTERN) ? SFR_MAX_PATTERN : int'(cfg_pat_len);
		for (int k = 0; k < pieces; k++) begin
			pick = $urandom_range(0, 3);
			if (!well_formed || plen == 0 || pick == 3) begin
				pos = $urandom_range(0, SFR_MAX_PATTERN - 1);
				sym = (well_formed && $urandom_range(0, 1) != 0) ?
					cfg_pattern[8*pos +: 8] : 8'($urandom);
				send_byte(1'b0, sym, calm);
			end else begin
				cut = (pick == 2) ? $urandom_range(1, plen) : plen;
				for (int j = 0; j < cut; j++)
					send_byte(1'b0, cfg_pattern[8*j +: 8], calm);
			end
		end
		send_byte(1'b1, 8'($urandom), calm);
	endtask

	function automatic plan_row_t item_row(input logic fn, input logic [7:0] b);
		plan_row_t row;
		row = '{kind: ROW_ITEM, fn: fn, b: b, idx: '0, data: '0, typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t typed_row(input logic fn, input logic [7:0] b,
		input logic [7:0] ob, input logic has, input logic eos);
		plan_row_t row;
		row = item_row(fn, b);
		row.typed = 1'b1;
		row.want.ob = ob;
		row.want.has = has;
		row.want.eos = eos;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row = '{kind: ROW_CFG, fn: 1'b0, b: 8'h00, idx: idx, data: data, typed: 1'b0, want: '0};
		return row;
	endfunction

	// ---------------- main sequence ----------------

	initial begin : stimulus
		plan_row_t plan[$];
		int        first_random;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		feed_ch.valid = 1'b0;
		feed_ch.func = 1'b0;
		feed_ch.in_byte = 8'h00;
		hold_request = 1'b0;
		error_count = 0;
		results_checked = 0;
		items_sent = 0;
		strings_done = 0;
		reg_writes = 0;

		// predictor starts from the reset state
		cfg_pattern = '0;
		cfg_pat_len = '0;
		cfg_repl = '0;
		cfg_repl_len = '0;
		cfg_limit_on = 1'b0;
		cfg_limit = '0;
		in_string = 1'b0;
		held_count = 0;
		for (int i = 0; i < SFR_MAX_PATTERN; i++)
			held_bytes[i] = 8'h00;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: insertion mode with an empty replacement, bytes pass as is
		plan.push_back(typed_row(1'b0, 8'h00, 8'h00, 1'b1, 1'b0));
		plan.push_back(typed_row(1'b0, 8'hFF, 8'hFF, 1'b1, 1'b0));
		plan.push_back(typed_row(1'b1, 8'hFF, 8'h00, 1'b0, 1'b1));
		plan.push_back(typed_row(1'b1, 8'h00, 8'h00, 1'b0, 1'b1));
		// "ab" -> "XYZ", one replacement allowed
		plan.push_back(cfg_row(REG_PATTERN_BYTES, 64'h6261));
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd2));
		plan.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h5A5958));
		plan.push_back(cfg_row(REG_REPLACEMENT_LEN, 64'd3));
		plan.push_back(cfg_row(REG_LIMIT_ENABLED, 64'd1));
		plan.push_back(cfg_row(REG_REPLACE_LIMIT, 64'd1));
		plan.push_back(item_row(1'b0, 8'h61));
		plan.push_back(item_row(1'b0, 8'h62));
		plan.push_back(item_row(1'b0, 8'h61));
		plan.push_back(item_row(1'b1, 8'h00));
		// limit of zero: string passes through
		plan.push_back(cfg_row(REG_REPLACE_LIMIT, 64'd0));
		plan.push_back(item_row(1'b0, 8'h61));
		plan.push_back(item_row(1'b0, 8'h62));
		plan.push_back(item_row(1'b1, 8'h00));
		// unlimited, empty replacement: whole string vanishes, end marker only
		plan.push_back(cfg_row(REG_LIMIT_ENABLED, 64'd0));
		plan.push_back(cfg_row(REG_REPLACEMENT_LEN, 64'd0));
		plan.push_back(item_row(1'b0, 8'h61));
		plan.push_back(item_row(1'b0, 8'h62));
		plan.push_back(item_row(1'b1, 8'h00));
		// oversized lengths clip to eight, widest limit
		plan.push_back(cfg_row(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd15));
		plan.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF));
		plan.push_back(cfg_row(REG_REPLACEMENT_LEN, 64'd15));
		plan.push_back(cfg_row(REG_LIMIT_ENABLED, 64'd1));
		plan.push_back(cfg_row(REG_REPLACE_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF));
		for (int i = 0; i < SFR_MAX_PATTERN; i++)
			plan.push_back(item_row(1'b0, 8'hFF));
		plan.push_back(item_row(1'b1, 8'hFF));
		// insertion mode with an eight-byte replacement; a write mid-string waits
		// for the next string
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd0));
		plan.push_back(cfg_row(REG_REPLACEMENT_LEN, 64'd8));
		plan.push_back(item_row(1'b1, 8'h00));
		plan.push_back(item_row(1'b0, 8'h5A));
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
		plan.push_back(item_row(1'b1, 8'hFF));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				idle_feed(pick_gap(1'b0));
				send_item(plan[i].fn, plan[i].b, plan[i].typed, plan[i].want);
			end
		end

		// long result hold while the feed keeps offering bytes
		settle();
		first_random = items_sent;
		hold_request = 1'b1;
		for (int k = 0; k < 20; k++)
			send_byte(1'b0, 8'($urandom), 1'b1);
		send_byte(1'b1, 8'($urandom), 1'b1);

		// random settings, a few strings per setting
		while (items_sent - first_random < RANDOM_ITEMS) begin
			settle();
			random_settings();
			repeat ($urandom_range(2, 4))
				random_string($urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0, 4);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d input items in %0d strings with %0d register writes,",
			items_sent, strings_done, reg_writes);
		$display("one long result hold included; %0d result items compared.", results_checked);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit
	initial begin : watchdog
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
